// ----- hdl/upsd_pkg.sv -----
// ----------------------------------------------------------------------------
// upsd_pkg
// Types, constants and helper functions for the URI path splitter.
// ----------------------------------------------------------------------------
package upsd_pkg;

    localparam int MAX_COMPONENT_BYTES = 4095;
    localparam int LEN_W               = 12;
    localparam int LEN_CAP_INT         = (MAX_COMPONENT_BYTES < 4095) ? MAX_COMPONENT_BYTES
                                                                      : 4095;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_CAP_INT[LEN_W-1:0];

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CFG_LIMIT_RESET = 8'd15;
    localparam logic [7:0] COUNT_MAX  = 8'hff;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic [7:0]       comp_index;
        logic             comp_end;
        logic [LEN_W-1:0] comp_len;
        logic             uri_done;
        logic [7:0]       comp_count;
        logic             truncated;
        logic             last;
    } result_t;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            v = 4'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46)
            v = 4'(c - 8'h41 + 8'h0a);
        else if (c >= 8'h61 && c <= 8'h66)
            v = 4'(c - 8'h61 + 8'h0a);
        return v;
    endfunction

    function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] len);
        return (len < LEN_CAP) ? len + 1'b1 : len;
    endfunction

    function automatic logic [7:0] count_inc(input logic [7:0] cnt);
        return (cnt < COUNT_MAX) ? cnt + 1'b1 : cnt;
    endfunction

    function automatic result_t mk_byte(input logic [7:0] b, input logic [7:0] idx);
        result_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.comp_index = idx;
        return r;
    endfunction

    function automatic result_t mk_close(input logic [7:0] idx, input logic [LEN_W-1:0] len,
                                         input logic done, input logic [7:0] cnt,
                                         input logic trunc);
        result_t r;
        r            = '0;
        r.comp_index = idx;
        r.comp_end   = 1'b1;
        r.comp_len   = len;
        r.uri_done   = done;
        r.comp_count = cnt;
        r.truncated  = trunc;
        return r;
    endfunction

endpackage

// ----- hdl/upsd_char_if.sv -----
// ----------------------------------------------------------------------------
// upsd_char_if
// Character channel into the URI path splitter.
// ----------------------------------------------------------------------------
interface upsd_char_if;

    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);

endinterface

// ----- hdl/upsd_res_if.sv -----
// ----------------------------------------------------------------------------
// upsd_res_if
// Result channel out of the URI path splitter.
// ----------------------------------------------------------------------------
interface upsd_res_if
    import upsd_pkg::*;
;

    logic             valid;
    logic             ready;
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic [7:0]       comp_index;
    logic             comp_end;
    logic [LEN_W-1:0] comp_len;
    logic             uri_done;
    logic [7:0]       comp_count;
    logic             truncated;
    logic             last;

    modport source (output valid, output out_byte, output byte_valid, output comp_index,
                    output comp_end, output comp_len, output uri_done, output comp_count,
                    output truncated, output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input comp_index,
                    input comp_end, input comp_len, input uri_done, input comp_count,
                    input truncated, input last, output ready);

endinterface

// ----- hdl/uri_path_splitter_percent_decode_top.sv -----
// Latency: the first result of a character is valid the cycle after it is accepted.
// Throughput: one character per cycle while each gives at most one result and the
// sink is ready; a character closing a component behind a held '%' gives up to three
// results, drained one per ready cycle from the result buffer that holds the input.
// Reset: asynchronous, active low; clears the path state, limit returns to 15.
// ----------------------------------------------------------------------------
// uri_path_splitter_percent_decode_top
// Splits a URI path into components and percent-decodes each component.
// ----------------------------------------------------------------------------
module uri_path_splitter_percent_decode_top
    import upsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    upsd_char_if.sink         uri,
    upsd_res_if.source        result
);

    // configuration
    logic [7:0]       limit_reg;

    // path state
    logic [7:0]       held0_reg, held0_next;
    logic [7:0]       held1_reg, held1_next;
    logic [1:0]       held_cnt_reg, held_cnt_next;
    logic             start_reg, start_next;
    logic             open_reg, open_next;
    logic [7:0]       seen_reg, seen_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             dropped_reg, dropped_next;

    // result buffer, entry 0 is presented
    result_t          res_reg [3];
    result_t          res_next [3];
    logic [1:0]       res_cnt_reg;
    logic [1:0]       n_res;

    logic             in_fire;
    logic             out_fire;
    logic             is_end;
    logic [1:0]       held_eff;
    logic [1:0]       n_flush;
    logic [LEN_W-1:0] len_eff, len_a, len_b, len_flushed;
    logic [7:0]       decoded;

    assign out_fire  = result.valid && result.ready;
    assign uri.ready = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && result.ready);
    assign in_fire   = uri.valid && uri.ready;

    assign result.valid      = (res_cnt_reg != 2'd0);
    assign result.out_byte   = res_reg[0].out_byte;
    assign result.byte_valid = res_reg[0].byte_valid;
    assign result.comp_index = res_reg[0].comp_index;
    assign result.comp_end   = res_reg[0].comp_end;
    assign result.comp_len   = res_reg[0].comp_len;
    assign result.uri_done   = res_reg[0].uri_done;
    assign result.comp_count = res_reg[0].comp_count;
    assign result.truncated  = res_reg[0].truncated;
    assign result.last       = res_reg[0].last;

    assign is_end  = uri.kind || (uri.ch == CH_NUL);
    assign decoded = {hex_value(held1_reg), hex_value(uri.ch)};

    always_comb
    begin
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        held_cnt_next = held_cnt_reg;
        start_next   = start_reg;
        open_next    = open_reg;
        seen_next    = seen_reg;
        len_next     = len_reg;
        dropped_next = dropped_reg;
        n_res        = 2'd0;
        for (int i = 0; i < 3; i++)
            res_next[i] = '0;

        // a closed component restarts with zero length and nothing held
        held_eff = open_reg ? held_cnt_reg : 2'd0;
        len_eff  = open_reg ? len_reg : '0;
        n_flush  = (held_eff == 2'd0) ? 2'd0 : (held_eff == 2'd1) ? 2'd1 : 2'd2;
        len_a    = len_inc(len_eff);
        len_b    = len_inc(len_a);
        case (n_flush)
            2'd0:    len_flushed = len_eff;
            2'd1:    len_flushed = len_a;
            default: len_flushed = len_b;
        endcase

        if (is_end)
        begin
            if (open_reg)
            begin
                // held '%' sequence goes out literally ahead of the close
                case (n_flush)
                    2'd0:
                    begin
                        res_next[0] = mk_close(seen_reg, len_flushed, 1'b1,
                                               count_inc(seen_reg), dropped_reg);
                        n_res = 2'd1;
                    end
                    2'd1:
                    begin
                        res_next[0] = mk_byte(held0_reg, seen_reg);
                        res_next[1] = mk_close(seen_reg, len_flushed, 1'b1,
                                               count_inc(seen_reg), dropped_reg);
                        n_res = 2'd2;
                    end
                    default:
                    begin
                        res_next[0] = mk_byte(held0_reg, seen_reg);
                        res_next[1] = mk_byte(held1_reg, seen_reg);
                        res_next[2] = mk_close(seen_reg, len_flushed, 1'b1,
                                               count_inc(seen_reg), dropped_reg);
                        n_res = 2'd3;
                    end
                endcase
            end
            else
            begin
                res_next[0]            = '0;
                res_next[0].uri_done   = 1'b1;
                res_next[0].comp_count = seen_reg;
                res_next[0].truncated  = dropped_reg;
                n_res = 2'd1;
            end
            held_cnt_next = 2'd0;
            start_next    = 1'b1;
            open_next     = 1'b0;
            seen_next     = '0;
            len_next      = '0;
            dropped_next  = 1'b0;
        end
        else if (start_reg && uri.ch == CH_SLASH)
        begin
            start_next = 1'b0;
        end
        else if (!open_reg && seen_reg >= limit_reg)
        begin
            start_next   = 1'b0;
            dropped_next = 1'b1;
        end
        else
        begin
            start_next = 1'b0;
            open_next  = 1'b1;
            if (uri.ch == CH_SLASH)
            begin
                case (n_flush)
                    2'd0:
                    begin
                        res_next[0] = mk_close(seen_reg, len_flushed, 1'b0, '0, 1'b0);
                        n_res = 2'd1;
                    end
                    2'd1:
                    begin
                        res_next[0] = mk_byte(held0_reg, seen_reg);
                        res_next[1] = mk_close(seen_reg, len_flushed, 1'b0, '0, 1'b0);
                        n_res = 2'd2;
                    end
                    default:
                    begin
                        res_next[0] = mk_byte(held0_reg, seen_reg);
                        res_next[1] = mk_byte(held1_reg, seen_reg);
                        res_next[2] = mk_close(seen_reg, len_flushed, 1'b0, '0, 1'b0);
                        n_res = 2'd3;
                    end
                endcase
                held_cnt_next = 2'd0;
                open_next     = 1'b0;
                len_next      = '0;
                seen_next     = count_inc(seen_reg);
            end
            else if (held_eff == 2'd0)
            begin
                len_next = len_eff;
                held_cnt_next = 2'd0;
                if (uri.ch == CH_PERCENT)
                begin
                    held0_next    = uri.ch;
                    held_cnt_next = 2'd1;
                end
                else
                begin
                    res_next[0] = mk_byte(uri.ch, seen_reg);
                    n_res       = 2'd1;
                    len_next    = len_a;
                end
            end
            else if (held_eff == 2'd1)
            begin
                held1_next    = uri.ch;
                held_cnt_next = 2'd2;
            end
            else
            begin
                res_next[0]   = mk_byte(decoded, seen_reg);
                n_res         = 2'd1;
                len_next      = len_a;
                held_cnt_next = 2'd0;
            end
        end

        case (n_res)
            2'd1:    res_next[0].last = 1'b1;
            2'd2:    res_next[1].last = 1'b1;
            2'd3:    res_next[2].last = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= CFG_LIMIT_RESET;
            held_cnt_reg <= 2'd0;
            start_reg    <= 1'b1;
            open_reg     <= 1'b0;
            seen_reg     <= '0;
            len_reg      <= '0;
            dropped_reg  <= 1'b0;
            res_cnt_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
            if (in_fire)
            begin
                held_cnt_reg <= held_cnt_next;
                start_reg    <= start_next;
                open_reg     <= open_next;
                seen_reg     <= seen_next;
                len_reg      <= len_next;
                dropped_reg  <= dropped_next;
                res_cnt_reg  <= n_res;
            end
            else if (out_fire)
            begin
                res_cnt_reg <= res_cnt_reg - 2'd1;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            for (int i = 0; i < 3; i++)
                res_reg[i] <= res_next[i];
        end
        else if (out_fire)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

endmodule

// ----- tb/uri_path_splitter_percent_decode_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uri_path_splitter_percent_decode_top_tb
// Streams URI characters into the splitter under random source gaps and sink
// stalls, predicts every decoded byte, component close and end-of-URI
// transaction, and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module uri_path_splitter_percent_decode_top_tb;

    import upsd_pkg::*;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } char_item_t;

    localparam int unsigned IDLE_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       quiet = 1'b0;

    upsd_char_if uri_ch();
    upsd_res_if  res_ch();

    uri_path_splitter_percent_decode_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .uri         (uri_ch),
        .result      (res_ch)
    );

    always #5 clk = ~clk;

    char_item_t  char_q[$];
    result_t     path_results_q[$];
    result_t     step_q[$];
    int unsigned items_made = 0;
    int unsigned errors = 0;
    string       hex_chars = "0123456789abcdefABCDEF:@`Gg";

    // predictor state
    logic [7:0]       cfg_limit = CFG_LIMIT_RESET;
    logic [7:0]       held_buf [2];
    logic [1:0]       held_cnt = 2'd0;
    logic             at_start = 1'b1;
    logic             comp_open = 1'b0;
    logic [7:0]       comps_seen = 8'd0;
    logic [LEN_W-1:0] comp_len_r = '0;
    logic             dropped = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 8'd10);
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 8'd10);
        return 4'd0;
    endfunction

    function automatic void clear_path();
        held_cnt   = 2'd0;
        at_start   = 1'b1;
        comp_open  = 1'b0;
        comps_seen = 8'd0;
        comp_len_r = '0;
        dropped    = 1'b0;
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        result_t r;
        r            = '0;
        r.out_byte   = b;
        r.byte_valid = 1'b1;
        r.comp_index = comps_seen;
        step_q.push_back(r);
        if (comp_len_r < LEN_CAP)
            comp_len_r = comp_len_r + 1'b1;
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_cnt; i++)
            add_byte(held_buf[i]);
        held_cnt = 2'd0;
    endfunction

    // Works out the result transactions caused by one accepted character.
    function automatic void split_char(input logic kind, input logic [7:0] c);
        result_t r;
        logic    skip;
        step_q.delete();
        r    = '0;
        skip = 1'b0;
        if (kind || c == CH_NUL) begin
            r.uri_done  = 1'b1;
            r.truncated = dropped;
            if (comp_open) begin
                flush_held();
                r.comp_index = comps_seen;
                r.comp_end   = 1'b1;
                r.comp_len   = comp_len_r;
                if (comps_seen < COUNT_MAX)
                    comps_seen = comps_seen + 1'b1;
            end
            r.comp_count = comps_seen;
            step_q.push_back(r);
            clear_path();
        end
        else begin
            if (at_start) begin
                at_start = 1'b0;
                if (c == CH_SLASH)
                    skip = 1'b1;
            end
            if (!skip && !comp_open) begin
                if (comps_seen >= cfg_limit) begin
                    dropped = 1'b1;
                    skip    = 1'b1;
                end
                else begin
                    comp_open  = 1'b1;
                    comp_len_r = '0;
                    held_cnt   = 2'd0;
                end
            end
            if (!skip) begin
                if (c == CH_SLASH) begin
                    flush_held();
                    r.comp_index = comps_seen;
                    r.comp_end   = 1'b1;
                    r.comp_len   = comp_len_r;
                    step_q.push_back(r);
                    comp_open  = 1'b0;
                    comp_len_r = '0;
                    if (comps_seen < COUNT_MAX)
                        comps_seen = comps_seen + 1'b1;
                end
                else if (held_cnt == 2'd0) begin
                    if (c == CH_PERCENT) begin
                        held_buf[0] = c;
                        held_cnt    = 2'd1;
                    end
                    else
                        add_byte(c);
                end
                else if (held_cnt == 2'd1) begin
                    held_buf[1] = c;
                    held_cnt    = 2'd2;
                end
                else begin
                    add_byte({hex_nibble(held_buf[1]), hex_nibble(c)});
                    held_cnt = 2'd0;
                end
            end
        end
        if (step_q.size() > 0) begin
            r      = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
        end
        foreach (step_q[i])
            path_results_q.push_back(step_q[i]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // character source
    always @(posedge clk) begin : char_drive
        char_item_t it;
        int unsigned send_gap;
        if (!rst_n) begin
            uri_ch.valid <= 1'b0;
            uri_ch.kind  <= 1'b0;
            uri_ch.ch    <= 8'd0;
            send_gap = 0;
        end
        else if (!uri_ch.valid || uri_ch.ready) begin
            if (send_gap > 0) begin
                send_gap--;
                uri_ch.valid <= 1'b0;
            end
            else if (char_q.size() > 0) begin
                it = char_q.pop_front();
                uri_ch.valid <= 1'b1;
                uri_ch.kind  <= it.kind;
                uri_ch.ch    <= it.ch;
                send_gap = quiet ? 0 : pick_gap();
            end
            else
                uri_ch.valid <= 1'b0;
        end
    end

    // result sink back-pressure
    always @(posedge clk) begin : res_stall
        int unsigned stall;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall = 0;
        end
        else if (stall > 0) begin
            stall--;
            res_ch.ready <= 1'b0;
        end
        else begin
            res_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 3) == 0)
                stall = pick_gap();
        end
    end

    // Check results first so a transaction of this edge never meets its own prediction.
    always @(posedge clk) begin : path_monitor
        result_t exp_r;
        if (!rst_n) begin
            cfg_limit = CFG_LIMIT_RESET;
            clear_path();
        end
        else begin
            if (cfg_wr_en)
                cfg_limit = cfg_wr_data;
            if (res_ch.valid && res_ch.ready) begin
                if (path_results_q.size() == 0) begin
                    $error("unexpected result transaction: comp_index %0d", res_ch.comp_index);
                    errors++;
                end
                else begin
                    exp_r = path_results_q.pop_front();
                    check_field("out_byte", 32'(exp_r.out_byte), 32'(res_ch.out_byte));
                    check_field("byte_valid", 32'(exp_r.byte_valid), 32'(res_ch.byte_valid));
                    check_field("comp_index", 32'(exp_r.comp_index), 32'(res_ch.comp_index));
                    check_field("comp_end", 32'(exp_r.comp_end), 32'(res_ch.comp_end));
                    check_field("comp_len", 32'(exp_r.comp_len), 32'(res_ch.comp_len));
                    check_field("uri_done", 32'(exp_r.uri_done), 32'(res_ch.uri_done));
                    check_field("comp_count", 32'(exp_r.comp_count), 32'(res_ch.comp_count));
                    check_field("truncated", 32'(exp_r.truncated), 32'(res_ch.truncated));
                    check_field("last", 32'(exp_r.last), 32'(res_ch.last));
                end
            end
            if (uri_ch.valid && uri_ch.ready)
                split_char(uri_ch.kind, uri_ch.ch);
        end
    end

    always @(posedge clk) begin : watchdog
        int unsigned idle_cycles;
        if (!rst_n)
            idle_cycles = 0;
        else if ((uri_ch.valid && uri_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("uri_path_splitter_percent_decode_top: mismatch");
                $finish;
            end
        end
    end

    task automatic push_char(input logic kind, input logic [7:0] c);
        char_item_t it;
        it.kind = kind;
        it.ch   = c;
        char_q.push_back(it);
        items_made++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(1'b0, s[i]);
    endtask

    task automatic push_end();
        push_char(1'b1, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_hex();
        return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
    endfunction

    // Mostly well-formed paths with random content, some raw noise.
    task automatic push_random_uri();
        int unsigned ncomp;
        int unsigned clen;
        int unsigned r;
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 10))
                push_char(1'b0, 8'($urandom_range(1, 255)));
        end
        else begin
            if ($urandom_range(0, 9) < 7)
                push_char(1'b0, CH_SLASH);
            ncomp = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 18) : $urandom_range(0, 4);
            for (int k = 0; k < ncomp; k++) begin
                if (k > 0)
                    push_char(1'b0, CH_SLASH);
                clen = $urandom_range(0, 5);
                for (int j = 0; j < clen; j++) begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        push_char(1'b0, 8'("a" + $urandom_range(0, 25)));
                    else if (r < 62) begin
                        push_char(1'b0, CH_PERCENT);
                        push_char(1'b0, pick_hex());
                        push_char(1'b0, pick_hex());
                    end
                    else if (r < 72) begin
                        push_char(1'b0, CH_PERCENT);
                        push_char(1'b0, pick_hex());
                    end
                    else if (r < 80)
                        push_char(1'b0, CH_PERCENT);
                    else
                        push_char(1'b0, 8'($urandom_range(1, 255)));
                end
            end
            if ($urandom_range(0, 4) == 0)
                push_char(1'b0, CH_SLASH);
        end
        if ($urandom_range(0, 6) == 0)
            push_char(1'b0, CH_NUL);
        else
            push_end();
    endtask

    task automatic push_random_batch(input int unsigned n);
        int unsigned target;
        target = items_made + n;
        while (items_made < target)
            push_random_uri();
    endtask

    // Idle means no character queued or in flight and no result outstanding;
    // then allow for characters that complete without any result.
    task automatic wait_drain();
        do
            @(negedge clk);
        while (char_q.size() != 0 || uri_ch.valid || path_results_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(input logic [7:0] v);
        wait_drain();
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 8'd0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: leading slash, decode, held percent at '/' and at end,
        // empty component, NUL terminator, bad hex digit, bare end of URI
        push_text("/a%41/");
        push_end();
        push_text("%4/%");
        push_end();
        push_text("//");
        push_char(1'b0, CH_NUL);
        push_char(1'b0, 8'hff);
        push_text("%gF%fa");
        push_end();
        push_end();

        set_limit(8'd1);
        push_random_batch(55);

        set_limit(8'd255);
        push_random_batch(55);

        set_limit(8'd0);
        push_random_batch(40);

        quiet = 1'b1;
        set_limit(8'($urandom_range(2, 8)));
        push_random_batch(55);

        wait_drain();
        quiet = 1'b0;
        set_limit(8'd4);
        push_random_batch(55);

        wait_drain();
        repeat (8) @(posedge clk);
        if (errors == 0 && path_results_q.size() == 0)
            $display("uri_path_splitter_percent_decode_top: match");
        else
            $display("uri_path_splitter_percent_decode_top: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/upsd_pkg.sv
hdl/upsd_char_if.sv
hdl/upsd_res_if.sv
hdl/uri_path_splitter_percent_decode_top.sv
tb/uri_path_splitter_percent_decode_top_tb.sv
